/* design/eiu_pkg.sv */
// Package for the x86-64 instruction encoder unit: words, queue entry,
// instruction kind codes and sizing constants. No dependencies.
package eiu_pkg;

    localparam int MaxCode     = 12;  // longest instruction in bytes
    localparam int LenW        = 4;   // holds 0..MaxCode
    localparam int QueueDepth  = 2;   // default front/back queue depth

    typedef enum logic [4:0] {
        F_RET        = 5'd0,
        F_MOV_R32IMM = 5'd1,
        F_MOV_R64IMM = 5'd2,
        F_MOV_RR     = 5'd3,
        F_ADD        = 5'd4,
        F_SUB        = 5'd5,
        F_IMUL       = 5'd6,
        F_CMP_RR     = 5'd7,
        F_CMP_IMM32  = 5'd8,
        F_CMP_IMM8   = 5'd9,
        F_TEST       = 5'd10,
        F_JE32       = 5'd11,
        F_JNE32      = 5'd12,
        F_JGE32      = 5'd13,
        F_JMP32      = 5'd14,
        F_CALL       = 5'd15,
        F_PROLOGUE   = 5'd16,
        F_EPILOGUE   = 5'd17,
        F_LOAD       = 5'd18,
        F_STORE      = 5'd19,
        F_CMP_MEM    = 5'd20,
        F_TEST_IMM   = 5'd21,
        F_JE8        = 5'd22,
        F_JMP8       = 5'd23,
        F_RAW8       = 5'd24,
        F_RAW32      = 5'd25,
        F_RAW64      = 5'd26
    } t_func;

    typedef struct packed {
        logic [4:0]         func;
        logic [3:0]         dst_reg;
        logic [3:0]         src_reg;
        logic signed [63:0] imm_value;
        logic [31:0]        disp_value;
    } t_in_word;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
    } t_out_word;

    // One encoded instruction: byte 0 goes out first.
    typedef struct packed {
        logic [MaxCode-1:0][7:0] code;
        logic [LenW-1:0]         len;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic busy;   // serializer still holds bytes of an instruction
    } t_back_status;

endpackage

/* design/eiu_front.sv */
// Front end of the encoder unit: takes a request word and encodes it into a
// queue entry. Depends on eiu_pkg.
module eiu_front (
    input  logic               i_valid,
    input  eiu_pkg::t_in_word  i_word,
    input  eiu_pkg::t_q_status i_q_status,
    output logic               o_stall,
    output logic               o_push,
    output eiu_pkg::t_entry    o_entry
);

    localparam logic [7:0] OpMovImm = 8'hB8;
    localparam logic [7:0] OpMovRm  = 8'h89;
    localparam logic [7:0] OpEsc    = 8'h0F;
    localparam logic [7:0] OpImul   = 8'hAF;
    localparam logic [7:0] OpGrp32  = 8'h81;
    localparam logic [7:0] OpGrp8   = 8'h83;
    localparam logic [7:0] OpMovRmR = 8'h8B;
    localparam logic [7:0] OpJmp32  = 8'hE9;
    localparam logic [7:0] OpRet    = 8'hC3;
    localparam logic [7:0] RexW     = 8'h48;

    function automatic eiu_pkg::t_entry put(eiu_pkg::t_entry e, logic [7:0] b);
        eiu_pkg::t_entry r;
        r = e;
        r.code[e.len] = b;
        r.len = e.len + 4'd1;
        return r;
    endfunction

    function automatic eiu_pkg::t_entry put32(eiu_pkg::t_entry e, logic [31:0] v);
        eiu_pkg::t_entry r;
        r = e;
        for (int i = 0; i < 4; i++) r = put(r, v[8*i +: 8]);
        return r;
    endfunction

    function automatic eiu_pkg::t_entry put64(eiu_pkg::t_entry e, logic [63:0] v);
        eiu_pkg::t_entry r;
        r = put32(e, v[31:0]);
        r = put32(r, v[63:32]);
        return r;
    endfunction

    // REX only when an extended register appears; R from reg, B from r/m.
    function automatic eiu_pkg::t_entry rex_opt(eiu_pkg::t_entry e, logic [3:0] r,
                                                logic [3:0] m);
        eiu_pkg::t_entry o;
        o = e;
        if (r[3] || m[3]) o = put(o, {5'b01000, r[3], 1'b0, m[3]});
        return o;
    endfunction

    function automatic eiu_pkg::t_entry rr_op(eiu_pkg::t_entry e, logic [7:0] op,
                                              logic twobyte, logic [3:0] r,
                                              logic [3:0] m);
        eiu_pkg::t_entry o;
        o = rex_opt(e, r, m);
        if (twobyte) o = put(o, OpEsc);
        o = put(o, op);
        o = put(o, {2'b11, r[2:0], m[2:0]});
        return o;
    endfunction

    function automatic eiu_pkg::t_entry mem_op(eiu_pkg::t_entry e, logic [7:0] op,
                                               logic [3:0] r, logic [3:0] base,
                                               logic [31:0] disp);
        eiu_pkg::t_entry o;
        o = rex_opt(e, r, base);
        o = put(o, op);
        o = put(o, {2'b10, r[2:0], base[2:0]});
        if (base[2:0] == 3'd4) o = put(o, 8'h24);   // SIB for rsp/r12 base
        o = put32(o, disp);
        return o;
    endfunction

    function automatic eiu_pkg::t_entry cmp_imm8(eiu_pkg::t_entry e, logic [3:0] reg_n,
                                                 logic [7:0] imm8);
        eiu_pkg::t_entry o;
        o = rex_opt(e, 4'd0, reg_n);
        o = put(o, OpGrp8);
        o = put(o, {5'b11111, reg_n[2:0]});
        o = put(o, imm8);
        return o;
    endfunction

    logic [3:0]  d;
    logic [3:0]  s;
    logic [63:0] imm;
    logic [31:0] lo32;
    eiu_pkg::t_entry e;

    assign d    = i_word.dst_reg;
    assign s    = i_word.src_reg;
    assign imm  = i_word.imm_value;
    assign lo32 = imm[31:0];

    always_comb begin
        e = '0;
        unique case (eiu_pkg::t_func'(i_word.func))
            eiu_pkg::F_RET: e = put(e, OpRet);
            eiu_pkg::F_MOV_R32IMM: begin
                if (d[3]) e = put(e, 8'h41);
                e = put(e, OpMovImm + {5'd0, d[2:0]});
                e = put32(e, lo32);
            end
            eiu_pkg::F_MOV_R64IMM: begin
                e = put(e, RexW | {7'd0, d[3]});
                e = put(e, OpMovImm + {5'd0, d[2:0]});
                e = put64(e, imm);
            end
            eiu_pkg::F_MOV_RR: begin
                e = put(e, RexW | {5'd0, s[3], 1'b0, d[3]});
                e = put(e, OpMovRm);
                e = put(e, {2'b11, s[2:0], d[2:0]});
            end
            eiu_pkg::F_ADD:    e = rr_op(e, 8'h01, 1'b0, s, d);
            eiu_pkg::F_SUB:    e = rr_op(e, 8'h29, 1'b0, s, d);
            eiu_pkg::F_IMUL:   e = rr_op(e, OpImul, 1'b1, d, s);
            eiu_pkg::F_CMP_RR: e = rr_op(e, 8'h39, 1'b0, s, d);
            eiu_pkg::F_CMP_IMM32: begin
                e = rex_opt(e, 4'd0, d);
                e = put(e, OpGrp32);
                e = put(e, {5'b11111, d[2:0]});
                e = put32(e, lo32);
            end
            eiu_pkg::F_CMP_IMM8: e = cmp_imm8(e, d, imm[7:0]);
            eiu_pkg::F_TEST:     e = rr_op(e, 8'h85, 1'b0, s, d);
            eiu_pkg::F_JE32: begin
                e = put(e, OpEsc);
                e = put(e, 8'h84);
                e = put32(e, lo32);
            end
            eiu_pkg::F_JNE32: begin
                e = put(e, OpEsc);
                e = put(e, 8'h85);
                e = put32(e, lo32);
            end
            eiu_pkg::F_JGE32: begin
                e = put(e, OpEsc);
                e = put(e, 8'h8D);
                e = put32(e, lo32);
            end
            eiu_pkg::F_JMP32: begin
                e = put(e, OpJmp32);
                e = put32(e, lo32);
            end
            eiu_pkg::F_CALL: begin
                // mov rax, imm64 ; call rax
                e = put(e, RexW);
                e = put(e, OpMovImm);
                e = put64(e, imm);
                e = put(e, 8'hFF);
                e = put(e, 8'hD0);
            end
            eiu_pkg::F_PROLOGUE: begin
                e = put(e, 8'h55);
                e = put(e, RexW);
                e = put(e, OpMovRm);
                e = put(e, 8'hE5);
                // positive locals count: sub rsp, (count mod 32)*8 as imm8
                if (lo32 != 32'd0 && !lo32[31]) begin
                    e = put(e, RexW);
                    e = put(e, OpGrp8);
                    e = put(e, 8'hEC);
                    e = put(e, {lo32[4:0], 3'b000});
                end
            end
            eiu_pkg::F_EPILOGUE: begin
                e = put(e, 8'hC9);
                e = put(e, OpRet);
            end
            eiu_pkg::F_LOAD:  e = mem_op(e, OpMovRmR, d, s, i_word.disp_value);
            eiu_pkg::F_STORE: e = mem_op(e, OpMovRm, d, s, i_word.disp_value);
            eiu_pkg::F_CMP_MEM: begin
                e = mem_op(e, OpGrp8, 4'd7, s, i_word.disp_value);
                e = put(e, imm[7:0]);
            end
            eiu_pkg::F_TEST_IMM: begin
                if (lo32 == 32'd0) e = rr_op(e, 8'h85, 1'b0, d, d);
                else               e = cmp_imm8(e, d, imm[7:0]);
            end
            eiu_pkg::F_JE8: begin
                e = put(e, 8'h74);
                e = put(e, imm[7:0]);
            end
            eiu_pkg::F_JMP8: begin
                e = put(e, 8'hEB);
                e = put(e, imm[7:0]);
            end
            eiu_pkg::F_RAW8:  e = put(e, imm[7:0]);
            eiu_pkg::F_RAW32: e = put32(e, lo32);
            eiu_pkg::F_RAW64: e = put64(e, imm);
            default: e = '0;   // unused kinds encode to nothing
        endcase
    end

    assign o_entry = e;
    assign o_stall = i_q_status.full;
    // empty encodings are accepted and dropped
    assign o_push  = i_valid && !i_q_status.full && (e.len != '0);

endmodule

/* design/eiu_queue.sv */
// Short FIFO of encoded instructions between front and back end.
// Depends on eiu_pkg.
module eiu_queue #(
    parameter int DEPTH = eiu_pkg::QueueDepth
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  eiu_pkg::t_entry    i_push_data,
    input  logic               i_pop,
    output eiu_pkg::t_entry    o_pop_data,
    output eiu_pkg::t_q_status o_status
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    eiu_pkg::t_entry r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        if (i_pop)  n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        if (i_push && !i_pop)      n_count = r_count + 1'b1;
        else if (!i_push && i_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_push_data;
    end

    assign o_pop_data     = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == FullCnt);
    assign o_status.empty = (r_count == '0);

endmodule

/* design/eiu_back.sv */
// Back end of the encoder unit: shifts an encoded instruction out one byte
// per cycle while not stalled, via a registered word. Depends on eiu_pkg.
module eiu_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  eiu_pkg::t_q_status    i_q_status,
    input  eiu_pkg::t_entry       i_q_data,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output eiu_pkg::t_out_word    o_out_word,
    output eiu_pkg::t_back_status o_status
);

    logic [eiu_pkg::MaxCode-1:0][7:0] r_code, n_code;
    logic [eiu_pkg::LenW-1:0]         r_left, n_left;
    logic                             r_out_valid;
    eiu_pkg::t_out_word               r_out_word;

    logic adv, emit, is_last;

    assign adv     = !r_out_valid || !i_out_stall;
    assign emit    = adv && (r_left != '0);
    assign is_last = (r_left == eiu_pkg::LenW'(1));
    assign o_pop   = !i_q_status.empty && ((r_left == '0) || (emit && is_last));

    always_comb begin
        n_code = r_code;
        n_left = r_left;
        if (o_pop) begin
            n_code = i_q_data.code;
            n_left = i_q_data.len;
        end else if (emit) begin
            n_code = {8'h00, r_code[eiu_pkg::MaxCode-1:1]};
            n_left = r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_left <= n_left;
            if (adv) r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        if (emit) begin
            r_out_word.code_byte <= r_code[0];
            r_out_word.last_byte <= is_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_word    = r_out_word;
    assign o_status.busy = (r_left != '0);

endmodule

/* design/x86_64_instruction_encoder_unit.sv */
// Top level of the x86-64 instruction encoder unit: front encoder, entry
// queue and byte serializer. Depends on eiu_pkg, eiu_front, eiu_queue, eiu_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word) takes one request
//   word: kind, two register numbers, immediate, displacement. The request
//   is encoded in the same cycle and written into a short queue.
//   Output channel (o_out_valid / i_out_stall / o_out_word) gives one code
//   byte per word, last_byte set on the final byte of each instruction.
//   Unused kind codes are accepted and produce no words.
// Path: an accepted request is written into the queue, then loaded into the
//   serializer, and its first byte then goes into the output register.
// Throughput: one output byte per cycle while i_out_stall is low, no gap between
//   instructions when the next is queued; a request of N bytes (1..12) holds the
//   serializer until its bytes are out. The byte-wide output register sets this
//   figure. Requests are taken every cycle while the queue has room.
// Stall: when i_out_stall is high the output word holds; the serializer and
//   then the queue fill, and o_in_stall rises once the queue is full.
// Reset (synchronous, active low): queue emptied, serializer idle, output
//   valid cleared. Code, queue memory and output word registers are not reset.
module x86_64_instruction_encoder_unit #(
    parameter int QUEUE_DEPTH = eiu_pkg::QueueDepth
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  eiu_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output eiu_pkg::t_out_word o_out_word
);

    eiu_pkg::t_q_status    q_status;
    eiu_pkg::t_entry       push_data;
    eiu_pkg::t_entry       pop_data;
    eiu_pkg::t_back_status back_status;
    logic                  push;
    logic                  pop;

    // Front: encode and push
    eiu_front u_front (
        .i_valid    (i_in_valid),
        .i_word     (i_in_word),
        .i_q_status (q_status),
        .o_stall    (o_in_stall),
        .o_push     (push),
        .o_entry    (push_data)
    );

    // Decoupling queue
    eiu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_status    (q_status)
    );

    // Back: byte serializer
    eiu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_q_data    (pop_data),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .o_status    (back_status)
    );

    // A byte that is not last leaves the rest of its instruction in the serializer.
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.last_byte) |-> back_status.busy)
        else $error("non-final byte shown with serializer empty");

    // The front never writes a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("push into full queue");

    // The serializer only pops a queue that holds an entry.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule

/* sim/tb_x86_64_instruction_encoder_unit.sv */
`timescale 1ns / 1ps
// Testbench for x86_64_instruction_encoder_unit: directed and random requests,
// each word's code bytes predicted in place and checked byte by byte.
// Depends on eiu_pkg and the encoder RTL.
module tb_x86_64_instruction_encoder_unit;

    // Run control
    localparam int CYCLE_LIMIT   = 200000;  // far above the slowest legal run
    localparam int RANDOM_WORDS  = 125;     // random requests with a real kind
    localparam int HOLD_CYCLES   = 200;     // one long output back-pressure burst
    localparam int HOLD_AT_BYTE  = 300;     // byte count that triggers the burst
    localparam int DRAIN_CYCLES  = 20;      // settle time after the last byte
    localparam int MAX_PRINTED   = 100;     // keeps a broken run's log short

    // Opcode and fixed ModRM/SIB/REX bytes
    localparam logic [7:0] OPC_RET        = 8'hC3;
    localparam logic [7:0] OPC_LEAVE      = 8'hC9;
    localparam logic [7:0] OPC_MOV_IMM    = 8'hB8;  // + low reg bits
    localparam logic [7:0] OPC_MOV_RM     = 8'h89;  // mov r/m, reg
    localparam logic [7:0] OPC_MOV_MR     = 8'h8B;  // mov reg, r/m
    localparam logic [7:0] OPC_ESC        = 8'h0F;  // two-byte opcode escape
    localparam logic [7:0] OPC_IMUL       = 8'hAF;
    localparam logic [7:0] OPC_ADD        = 8'h01;
    localparam logic [7:0] OPC_SUB        = 8'h29;
    localparam logic [7:0] OPC_CMP        = 8'h39;
    localparam logic [7:0] OPC_TEST       = 8'h85;
    localparam logic [7:0] OPC_GRP1_IMM32 = 8'h81;
    localparam logic [7:0] OPC_GRP1_IMM8  = 8'h83;
    localparam logic [7:0] OPC_JE_REL32   = 8'h84;
    localparam logic [7:0] OPC_JNE_REL32  = 8'h85;
    localparam logic [7:0] OPC_JGE_REL32  = 8'h8D;
    localparam logic [7:0] OPC_JMP_REL32  = 8'hE9;
    localparam logic [7:0] OPC_JE_REL8    = 8'h74;
    localparam logic [7:0] OPC_JMP_REL8   = 8'hEB;
    localparam logic [7:0] OPC_CALL_IND   = 8'hFF;
    localparam logic [7:0] OPC_PUSH_RBP   = 8'h55;
    localparam logic [7:0] MODRM_CALL_RAX = 8'hD0;
    localparam logic [7:0] MODRM_RBP_RSP  = 8'hE5;
    localparam logic [7:0] MODRM_SUB_RSP  = 8'hEC;
    localparam logic [7:0] MODRM_CMP_IMM  = 8'hF8;  // mod 11, /7, + reg
    localparam logic [7:0] SIB_RSP_BASE   = 8'h24;
    localparam logic [7:0] REX_BASE       = 8'h40;
    localparam logic [7:0] REX_B          = 8'h41;
    localparam logic [7:0] REX_W          = 8'h48;
    localparam logic [7:0] REX_WB         = 8'h49;
    localparam logic [3:0] EXT_CMP        = 4'd7;   // ModRM reg field of cmp

    typedef struct {
        eiu_pkg::t_in_word w;
        bit                drain_first;  // hold this word until every byte is back
    } t_pending;

    // Clock, reset and the block's inputs, all known from time zero
    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               in_valid  = 1'b0;
    eiu_pkg::t_in_word  in_word   = '0;
    logic               out_stall = 1'b0;
    logic               in_stall;
    logic               out_valid;
    eiu_pkg::t_out_word out_word;

    t_pending           pending_words[$];   // requests not yet offered
    eiu_pkg::t_out_word code_due[$];        // predicted bytes, oldest first
    logic [7:0]         enc_bytes[$];       // scratch for one instruction

    int                 mismatch_count = 0;
    int                 words_sent     = 0;
    int                 bytes_seen     = 0;
    int                 hold_left      = 0;
    bit                 hold_done      = 1'b0;
    int                 cycle_count    = 0;
    eiu_pkg::t_out_word byte_due;
    t_pending           next_pending;

    x86_64_instruction_encoder_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Encoding predictor. Builds one instruction in enc_bytes, then the
    // bytes are queued with last_byte on the final one.
    // ------------------------------------------------------------------
    function automatic void put_le(logic [63:0] v, int n);
        for (int i = 0; i < n; i++)
            enc_bytes.push_back(v[8*i +: 8]);
    endfunction

    // REX only when an extended register shows up: R from ModRM.reg,
    // B from ModRM.rm.
    function automatic void rex_opt(logic [3:0] r, logic [3:0] m);
        if (r[3] || m[3])
            enc_bytes.push_back(REX_BASE | {5'b0, r[3], 1'b0, m[3]});
    endfunction

    function automatic void rr_op(logic [7:0] op, bit two_byte, logic [3:0] r, logic [3:0] m);
        rex_opt(r, m);
        if (two_byte)
            enc_bytes.push_back(OPC_ESC);
        enc_bytes.push_back(op);
        enc_bytes.push_back({2'b11, r[2:0], m[2:0]});
    endfunction

    // [base + disp32]; rsp and r12 bases need the SIB byte
    function automatic void mem_op(logic [7:0] op, logic [3:0] r, logic [3:0] base,
                                   logic [31:0] disp);
        rex_opt(r, base);
        enc_bytes.push_back(op);
        enc_bytes.push_back({2'b10, r[2:0], base[2:0]});
        if (base[2:0] == 3'd4)
            enc_bytes.push_back(SIB_RSP_BASE);
        put_le({32'b0, disp}, 4);
    endfunction

    function automatic void cmp_imm8(logic [3:0] r, logic [63:0] imm);
        rex_opt(4'd0, r);
        enc_bytes.push_back(OPC_GRP1_IMM8);
        enc_bytes.push_back(MODRM_CMP_IMM | {5'b0, r[2:0]});
        enc_bytes.push_back(imm[7:0]);
    endfunction

    function automatic void predict_encoding(eiu_pkg::t_in_word w);
        logic [3:0]         d;
        logic [3:0]         s;
        logic [63:0]        imm;
        logic [31:0]        lo32;
        eiu_pkg::t_out_word ob;
        d    = w.dst_reg;
        s    = w.src_reg;
        imm  = w.imm_value;
        lo32 = imm[31:0];
        enc_bytes.delete();
        case (w.func)
            eiu_pkg::F_RET: enc_bytes.push_back(OPC_RET);
            eiu_pkg::F_MOV_R32IMM: begin
                // 32-bit move: no REX.W, only REX.B for r8..r15
                if (d[3])
                    enc_bytes.push_back(REX_B);
                enc_bytes.push_back(OPC_MOV_IMM | {5'b0, d[2:0]});
                put_le(imm, 4);
            end
            eiu_pkg::F_MOV_R64IMM: begin
                enc_bytes.push_back(d[3] ? REX_WB : REX_W);
                enc_bytes.push_back(OPC_MOV_IMM | {5'b0, d[2:0]});
                put_le(imm, 8);
            end
            eiu_pkg::F_MOV_RR: begin
                enc_bytes.push_back(REX_W | {5'b0, s[3], 1'b0, d[3]});
                enc_bytes.push_back(OPC_MOV_RM);
                enc_bytes.push_back({2'b11, s[2:0], d[2:0]});
            end
            eiu_pkg::F_ADD:    rr_op(OPC_ADD, 1'b0, s, d);
            eiu_pkg::F_SUB:    rr_op(OPC_SUB, 1'b0, s, d);
            eiu_pkg::F_IMUL:   rr_op(OPC_IMUL, 1'b1, d, s);
            eiu_pkg::F_CMP_RR: rr_op(OPC_CMP, 1'b0, s, d);
            eiu_pkg::F_CMP_IMM32: begin
                rex_opt(4'd0, d);
                enc_bytes.push_back(OPC_GRP1_IMM32);
                enc_bytes.push_back(MODRM_CMP_IMM | {5'b0, d[2:0]});
                put_le(imm, 4);
            end
            eiu_pkg::F_CMP_IMM8: cmp_imm8(d, imm);
            eiu_pkg::F_TEST:     rr_op(OPC_TEST, 1'b0, s, d);
            eiu_pkg::F_JE32: begin
                enc_bytes.push_back(OPC_ESC);
                enc_bytes.push_back(OPC_JE_REL32);
                put_le(imm, 4);
            end
            eiu_pkg::F_JNE32: begin
                enc_bytes.push_back(OPC_ESC);
                enc_bytes.push_back(OPC_JNE_REL32);
                put_le(imm, 4);
            end
            eiu_pkg::F_JGE32: begin
                enc_bytes.push_back(OPC_ESC);
                enc_bytes.push_back(OPC_JGE_REL32);
                put_le(imm, 4);
            end
            eiu_pkg::F_JMP32: begin
                enc_bytes.push_back(OPC_JMP_REL32);
                put_le(imm, 4);
            end
            eiu_pkg::F_CALL: begin
                // mov rax, imm64 ; call rax
                enc_bytes.push_back(REX_W);
                enc_bytes.push_back(OPC_MOV_IMM);
                put_le(imm, 8);
                enc_bytes.push_back(OPC_CALL_IND);
                enc_bytes.push_back(MODRM_CALL_RAX);
            end
            eiu_pkg::F_PROLOGUE: begin
                enc_bytes.push_back(OPC_PUSH_RBP);
                enc_bytes.push_back(REX_W);
                enc_bytes.push_back(OPC_MOV_RM);
                enc_bytes.push_back(MODRM_RBP_RSP);
                // sub rsp, (count mod 32)*8 only for a positive locals count
                if (lo32 != 32'd0 && !lo32[31]) begin
                    enc_bytes.push_back(REX_W);
                    enc_bytes.push_back(OPC_GRP1_IMM8);
                    enc_bytes.push_back(MODRM_SUB_RSP);
                    enc_bytes.push_back({lo32[4:0], 3'b000});
                end
            end
            eiu_pkg::F_EPILOGUE: begin
                enc_bytes.push_back(OPC_LEAVE);
                enc_bytes.push_back(OPC_RET);
            end
            eiu_pkg::F_LOAD:  mem_op(OPC_MOV_MR, d, s, w.disp_value);
            eiu_pkg::F_STORE: mem_op(OPC_MOV_RM, d, s, w.disp_value);
            eiu_pkg::F_CMP_MEM: begin
                mem_op(OPC_GRP1_IMM8, EXT_CMP, s, w.disp_value);
                enc_bytes.push_back(imm[7:0]);
            end
            eiu_pkg::F_TEST_IMM: begin
                // zero mask degenerates to test reg,reg
                if (lo32 == 32'd0)
                    rr_op(OPC_TEST, 1'b0, d, d);
                else
                    cmp_imm8(d, imm);
            end
            eiu_pkg::F_JE8: begin
                enc_bytes.push_back(OPC_JE_REL8);
                enc_bytes.push_back(imm[7:0]);
            end
            eiu_pkg::F_JMP8: begin
                enc_bytes.push_back(OPC_JMP_REL8);
                enc_bytes.push_back(imm[7:0]);
            end
            eiu_pkg::F_RAW8:  enc_bytes.push_back(imm[7:0]);
            eiu_pkg::F_RAW32: put_le(imm, 4);
            eiu_pkg::F_RAW64: put_le(imm, 8);
            default: ;  // unused kinds give no bytes
        endcase
        foreach (enc_bytes[i]) begin
            ob.code_byte = enc_bytes[i];
            ob.last_byte = (i == enc_bytes.size() - 1);
            code_due.push_back(ob);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic eiu_pkg::t_in_word make_word(logic [4:0] f, logic [3:0] d,
                                                    logic [3:0] s, logic [63:0] imm,
                                                    logic [31:0] disp);
        eiu_pkg::t_in_word w;
        w.func       = f;
        w.dst_reg    = d;
        w.src_reg    = s;
        w.imm_value  = imm;
        w.disp_value = disp;
        return w;
    endfunction

    function automatic void queue_word(eiu_pkg::t_in_word w, bit drain_first);
        t_pending p;
        p.w           = w;
        p.drain_first = drain_first;
        pending_words.push_back(p);
    endfunction

    // Mostly real kinds, a few unused codes; locals count and test mask
    // are often forced to zero or a small count to reach both branches.
    function automatic eiu_pkg::t_in_word random_word();
        eiu_pkg::t_in_word w;
        if ($urandom_range(19) == 0)
            w.func = 5'($urandom_range(31, 27));
        else
            w.func = 5'($urandom_range(26));
        w.dst_reg    = 4'($urandom);
        w.src_reg    = 4'($urandom);
        w.imm_value  = {$urandom, $urandom};
        w.disp_value = $urandom;
        if (w.func == eiu_pkg::F_PROLOGUE || w.func == eiu_pkg::F_TEST_IMM) begin
            case ($urandom_range(2))
                0: w.imm_value[31:0] = 32'd0;
                1: w.imm_value[31:0] = 32'($urandom_range(40));
                default: ;
            endcase
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers words from pending_words. A word that is accepted is
    // predicted in the same step. Gaps ~33% except for a calm window.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) begin
                predict_encoding(in_word);
                words_sent++;
            end
            if (pending_words.size() == 0) begin
                in_valid <= 1'b0;
            end else if (pending_words[0].drain_first && code_due.size() != 0) begin
                in_valid <= 1'b0;   // pause until the block has emptied out
            end else if (!(words_sent >= 90 && words_sent < 130) &&
                         $urandom_range(99) < 33) begin
                in_valid <= 1'b0;
            end else begin
                next_pending = pending_words.pop_front();
                in_word  <= next_pending.w;
                in_valid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Long hold: once enough bytes are through, the receiver holds off
    // in one long burst while the sender keeps offering.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && bytes_seen >= HOLD_AT_BYTE) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks every accepted byte against the oldest prediction
    // and drives the output stall: the long hold (the queue fills and the
    // input stalls), a calm window, and random ~33% stalls otherwise.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                bytes_seen++;
                if (code_due.size() == 0) begin
                    report_mismatch($sformatf("byte %0d: unexpected %02h last %0b",
                                              bytes_seen, out_word.code_byte,
                                              out_word.last_byte));
                end else begin
                    byte_due = code_due.pop_front();
                    if (out_word.code_byte !== byte_due.code_byte)
                        report_mismatch($sformatf("byte %0d: code_byte %02h, want %02h",
                                                  bytes_seen, out_word.code_byte,
                                                  byte_due.code_byte));
                    if (out_word.last_byte !== byte_due.last_byte)
                        report_mismatch($sformatf("byte %0d: last_byte %0b, want %0b",
                                                  bytes_seen, out_word.last_byte,
                                                  byte_due.last_byte));
                end
            end
            if (hold_left != 0) begin
                out_stall <= 1'b1;
            end else if (bytes_seen >= 450 && bytes_seen < 650) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(99) < 33);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: fill the request list, release reset, wait for the last
    // byte, settle, report.
    // ------------------------------------------------------------------
    initial begin
        int real_kinds;
        eiu_pkg::t_in_word w;
        real_kinds = 0;

        // Directed: every kind 0..27 once. Immediate and displacement alternate
        // between their extremes, dst/src registers between 4/12 and 15/4; the
        // picks put an r12 or rsp base under the memory forms (SIB byte), a zero
        // locals count under the prologue and a zero mask under test-immediate.
        for (int f = 0; f < 28; f++)
            queue_word(make_word(5'(f), f[0] ? 4'd15 : 4'd4, f[0] ? 4'd4 : 4'd12,
                                 f[1] ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000,
                                 f[2] ? 32'hFFFF_FFFF : 32'h0), 1'b0);
        queue_word(make_word(eiu_pkg::F_RAW64 + 5'd5, 4'd0, 4'd0, '1, '1), 1'b0); // top unused
        queue_word(make_word(eiu_pkg::F_PROLOGUE, 4'd0, 4'd0, 64'hFFFF_FFFF_0000_0013,
                             32'd0), 1'b0);
        queue_word(make_word(eiu_pkg::F_PROLOGUE, 4'd0, 4'd0, 64'h0000_0000_8000_0000,
                             32'd0), 1'b0);
        queue_word(make_word(eiu_pkg::F_TEST_IMM, 4'd9, 4'd0, 64'h0000_0001_0000_0080,
                             32'd0), 1'b0);
        queue_word(make_word(eiu_pkg::F_LOAD, 4'd8, 4'd5, 64'd0, 32'h1234_5678),
                   1'b0);   // rbp base

        // Random part; words queued at real-kind count 1 or 110 wait for an empty pipeline.
        while (real_kinds < RANDOM_WORDS) begin
            w = random_word();
            if (w.func <= eiu_pkg::F_RAW64)
                real_kinds++;
            queue_word(w, real_kinds == 1 || real_kinds == 110);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || in_valid)
            @(posedge i_clk);
        while (code_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
